@@ hw/rtl/ptlm_pkg.sv @@
// Package for the prefix table longest-match block.
// Holds the field types, command and status codes, the table entry layout
// and the prefix mask helper. Depends on nothing.
package ptlm_pkg;

   // Field types of the request and response beats.
   typedef logic [1:0]  cmd_type;
   typedef logic [31:0] addr_type;
   typedef logic [5:0]  len_type;
   typedef logic [7:0]  peer_type;
   typedef logic [1:0]  status_type;

   // Command codes.
   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_LOOKUP = 2'd1;
   localparam cmd_type CMD_REMOVE = 2'd2;

   // Status codes.
   localparam status_type ST_OK   = 2'd0;
   localparam status_type ST_FULL = 2'd1;
   localparam status_type ST_MISS = 2'd2;

   // Longest legal prefix and an all-ones address.
   localparam len_type  LEN_MAX   = 6'd32;
   localparam addr_type FULL_MASK = 32'hFFFF_FFFF;

   // Default table depth.
   localparam int DEFAULT_TABLE_ENTRIES = 32;

   // One table slot as held in the entry memory.
   typedef struct packed {
      logic     valid;
      addr_type prefix;
      len_type  length;
      peer_type peer;
   } entry_type;

   // Mask that keeps the top len bits of an address; len is at most 32.
   function automatic addr_type len_mask(input len_type len);
      addr_type mask;
      mask = ~(FULL_MASK >> len);
      return mask;
   endfunction

endpackage

@@ hw/rtl/ptlm_if.sv @@
// Valid/ready channel interfaces for the prefix table block.
// One interface carries request beats, the other response beats.
// Depends on ptlm_pkg for the field types.
interface ptlm_req_if;
   logic              valid;
   logic              ready;
   ptlm_pkg::cmd_type  command;
   ptlm_pkg::addr_type ip_addr;
   ptlm_pkg::len_type  prefix_len;
   ptlm_pkg::peer_type peer_index;

   modport source (output valid, output command, output ip_addr, output prefix_len,
                   output peer_index, input ready);
   modport sink   (input valid, input command, input ip_addr, input prefix_len,
                   input peer_index, output ready);
endinterface

interface ptlm_rsp_if;
   logic                 valid;
   logic                 ready;
   ptlm_pkg::status_type status;
   ptlm_pkg::peer_type   found_peer;

   modport source (output valid, output status, output found_peer, input ready);
   modport sink   (input valid, input status, input found_peer, output ready);
endinterface

@@ hw/rtl/prefix_table_longest_match.sv @@
// Top level of the prefix table longest-match block.
// Holds the entry memory, the scan sequencer and the shared compare unit.
// Depends on ptlm_pkg and the channel interfaces in ptlm_if.sv.

// The block keeps TABLE_ENTRIES prefix slots in a single-port-read memory and
// serves one command at a time. After reset it runs a clearing pass over all
// TABLE_ENTRIES slots, during which no request beat is taken. Every command
// (insert, lookup, remove) then reads the table one slot per cycle through one
// compare unit, and the next request is accepted in the cycle after the
// response beat is taken. The memory read port, one slot per cycle, sets the
// pace of each scan.
module prefix_table_longest_match #(
   parameter int TABLE_ENTRIES = ptlm_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  logic clock,
   input  logic reset,
   ptlm_req_if.sink   req_chan,
   ptlm_rsp_if.source rsp_chan
);
   import ptlm_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] LAST_IDX  = CNT_W'(TABLE_ENTRIES - 1);
   localparam logic [CNT_W-1:0] TABLE_END = CNT_W'(TABLE_ENTRIES);

   // Sequencer states.
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_FINISH = 3'd3;
   localparam logic [2:0] S_RESP   = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             eval_vld_ff, eval_vld_in;
   logic [IDX_W-1:0] eval_idx_ff, eval_idx_in;

   // Captured request.
   cmd_type  cmd_ff, cmd_in;
   addr_type addr_ff, addr_in;
   addr_type key_ff, key_in;
   len_type  len_ff, len_in;
   peer_type peer_ff, peer_in;

   // Scan results.
   logic             done_ff, done_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             hit_ff, hit_in;
   len_type          best_len_ff, best_len_in;
   peer_type         best_peer_ff, best_peer_in;

   // Response register.
   logic       rsp_vld_ff, rsp_vld_in;
   status_type rsp_status_ff, rsp_status_in;
   peer_type   rsp_peer_ff, rsp_peer_in;

   // Entry memory ports.
   entry_type        table_mem [TABLE_ENTRIES];
   entry_type        rd_data_ff;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;

   logic    req_beat;
   len_type len_sat;
   logic    hit_lookup;
   logic    hit_insert;
   logic    hit_remove;

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign req_beat            = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid      = rsp_vld_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.found_peer = rsp_peer_ff;

   // Prefix lengths above the address width saturate.
   assign len_sat = (req_chan.prefix_len > LEN_MAX) ? LEN_MAX : req_chan.prefix_len;

   // Shared compare unit on the slot read in the previous cycle.
   assign hit_lookup = rd_data_ff.valid &&
                       ((addr_ff & len_mask(rd_data_ff.length)) == rd_data_ff.prefix);
   assign hit_insert = rd_data_ff.valid && (rd_data_ff.prefix == key_ff) &&
                       (rd_data_ff.length == len_ff);
   assign hit_remove = rd_data_ff.valid && (rd_data_ff.peer == peer_ff);

   // Entry memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   // Sequencer and scan bookkeeping.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      eval_vld_in   = 1'b0;
      eval_idx_in   = cnt_ff[IDX_W-1:0];
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      key_in        = key_ff;
      len_in        = len_ff;
      peer_in       = peer_ff;
      done_in       = done_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      hit_in        = hit_ff;
      best_len_in   = best_len_ff;
      best_peer_in  = best_peer_ff;
      rsp_vld_in    = rsp_vld_ff;
      rsp_status_in = rsp_status_ff;
      rsp_peer_in   = rsp_peer_ff;
      rd_en         = 1'b0;
      rd_addr       = cnt_ff[IDX_W-1:0];
      mem_we        = 1'b0;
      mem_waddr     = eval_idx_ff;
      mem_wdata     = '0;

      unique case (state_ff)
         S_CLEAR: begin
            // Clearing pass: one slot per cycle.
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[IDX_W-1:0];
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_beat) begin
               cmd_in        = req_chan.command;
               addr_in       = req_chan.ip_addr;
               key_in        = req_chan.ip_addr & len_mask(len_sat);
               len_in        = len_sat;
               peer_in       = req_chan.peer_index;
               done_in       = 1'b0;
               free_found_in = 1'b0;
               hit_in        = 1'b0;
               best_len_in   = '0;
               best_peer_in  = '0;
               cnt_in        = '0;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            // Issue the next read while the previous slot is evaluated.
            if (cnt_ff != TABLE_END) begin
               rd_en       = 1'b1;
               eval_vld_in = 1'b1;
               cnt_in      = cnt_ff + 1'b1;
            end else begin
               state_in = S_FINISH;
            end
            if (eval_vld_ff) begin
               unique case (cmd_ff)
                  CMD_INSERT: begin
                     if (hit_insert && !done_ff) begin
                        mem_we         = 1'b1;
                        mem_wdata      = rd_data_ff;
                        mem_wdata.peer = peer_ff;
                        done_in        = 1'b1;
                     end else if (!rd_data_ff.valid && !free_found_ff) begin
                        free_found_in = 1'b1;
                        free_idx_in   = eval_idx_ff;
                     end
                  end
                  CMD_LOOKUP: begin
                     if (hit_lookup && (!hit_ff || rd_data_ff.length > best_len_ff)) begin
                        hit_in       = 1'b1;
                        best_len_in  = rd_data_ff.length;
                        best_peer_in = rd_data_ff.peer;
                     end
                  end
                  CMD_REMOVE: begin
                     if (hit_remove) begin
                        mem_we = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FINISH: begin
            // Fill a free slot on a new insert and build the response beat.
            rsp_vld_in    = 1'b1;
            rsp_status_in = ST_OK;
            rsp_peer_in   = '0;
            state_in      = S_RESP;
            if (cmd_ff == CMD_INSERT && !done_ff) begin
               if (free_found_ff) begin
                  mem_we           = 1'b1;
                  mem_waddr        = free_idx_ff;
                  mem_wdata.valid  = 1'b1;
                  mem_wdata.prefix = key_ff;
                  mem_wdata.length = len_ff;
                  mem_wdata.peer   = peer_ff;
               end else begin
                  rsp_status_in = ST_FULL;
               end
            end else if (cmd_ff == CMD_LOOKUP) begin
               if (hit_ff) begin
                  rsp_peer_in = best_peer_ff;
               end else begin
                  rsp_status_in = ST_MISS;
               end
            end
         end
         S_RESP: begin
            if (rsp_chan.ready) begin
               rsp_vld_in = 1'b0;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         cnt_ff      <= '0;
         eval_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         eval_vld_ff <= eval_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      eval_idx_ff   <= eval_idx_in;
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      key_ff        <= key_in;
      len_ff        <= len_in;
      peer_ff       <= peer_in;
      done_ff       <= done_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      hit_ff        <= hit_in;
      best_len_ff   <= best_len_in;
      best_peer_ff  <= best_peer_in;
      rsp_status_ff <= rsp_status_in;
      rsp_peer_ff   <= rsp_peer_in;
   end

   // A request is never taken while a response beat is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request accepted while a response is pending");

   // An accepted request starts a scan at the first slot.
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == S_SCAN) && (cnt_ff == '0))
      else $error("scan did not start after an accepted request");

   // A lookup miss carries no peer.
   a_miss_peer: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_status_ff == ST_MISS) |-> (rsp_peer_ff == '0))
      else $error("lookup miss reported a peer");

   // Only an insert can report a full table.
   a_full_insert: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_status_ff == ST_FULL) |-> (cmd_ff == CMD_INSERT))
      else $error("full status on a command other than insert");

endmodule

@@ tb/prefix_table_longest_match_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the prefix table longest-match block: a queue-fed
// request driver, a response monitor and a predictor of the table checked beat by beat.
// Depends on ptlm_pkg, the channel interfaces in ptlm_if.sv and the top level.
module prefix_table_longest_match_tb;
   import ptlm_pkg::*;

   localparam int SLOTS = DEFAULT_TABLE_ENTRIES;
   localparam cmd_type CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1600;
   localparam int HOLD_AT = 400;
   localparam int HOLD_CYCLES = 400;
   localparam int QUIET_FROM = 900;
   localparam int QUIET_TO = 1150;
   localparam int DRAIN_CYCLES = 4 * (SLOTS + 3);
   localparam int unsigned LIMIT_CYCLES = 600000;
   localparam int RECENT_DEPTH = 48;

   typedef struct packed {
      cmd_type  command;
      addr_type ip_addr;
      len_type  prefix_len;
      peer_type peer_index;
   } route_req_type;

   typedef struct packed {
      status_type status;
      peer_type   found_peer;
   } route_rsp_type;

   logic clock;
   logic reset;
   ptlm_req_if req_if();
   ptlm_rsp_if rsp_if();

   prefix_table_longest_match #(.TABLE_ENTRIES(SLOTS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   // Pending request beats, expected response beats and run bookkeeping.
   route_req_type cmd_backlog[$];
   route_rsp_type awaited_rsp[$];
   route_req_type recent_prefixes[$];
   int            mismatches = 0;
   int            req_beats = 0;
   logic          req_taken = 1'b0;
   int            hold_left = 0;
   logic          hold_done = 1'b0;
   int unsigned   cycle_count = 0;

   // Predicted copy of the routing table.
   addr_type slot_prefix[SLOTS];
   len_type  slot_len[SLOTS];
   peer_type slot_peer[SLOTS];
   logic     slot_used[SLOTS];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic len_type clamp_len(input len_type len);
      return (len > LEN_MAX) ? LEN_MAX : len;
   endfunction

   // Keeps the top len bits of an address; len must be 0..32.
   function automatic addr_type prefix_mask(input len_type len);
      int unsigned sh;
      logic [32:0] low;
      sh = 32 - int'(len);
      low = (33'd1 << sh) - 33'd1;
      return ~low[31:0];
   endfunction

   // Applies one command to the predicted table and returns its response.
   function automatic route_rsp_type table_apply(input route_req_type r);
      len_type       len;
      addr_type      masked;
      int            free_slot;
      logic          done;
      logic          hit;
      len_type       best;
      route_rsp_type res;
      res.status = ST_OK;
      res.found_peer = '0;
      len = clamp_len(r.prefix_len);
      case (r.command)
         CMD_INSERT: begin
            masked = r.ip_addr & prefix_mask(len);
            free_slot = -1;
            done = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_used[i]) begin
                  if (!done && slot_prefix[i] == masked && slot_len[i] == len) begin
                     slot_peer[i] = r.peer_index;
                     done = 1'b1;
                  end
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (!done) begin
               if (free_slot >= 0) begin
                  slot_prefix[free_slot] = masked;
                  slot_len[free_slot] = len;
                  slot_peer[free_slot] = r.peer_index;
                  slot_used[free_slot] = 1'b1;
               end else begin
                  res.status = ST_FULL;
               end
            end
         end
         CMD_LOOKUP: begin
            hit = 1'b0;
            best = '0;
            // A strictly longer match replaces the best so far, so ties keep the lower slot.
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_used[i] && (r.ip_addr & prefix_mask(slot_len[i])) == slot_prefix[i]
                   && (!hit || slot_len[i] > best)) begin
                  hit = 1'b1;
                  best = slot_len[i];
                  res.found_peer = slot_peer[i];
               end
            end
            if (!hit) res.status = ST_MISS;
         end
         CMD_REMOVE: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_used[i] && slot_peer[i] == r.peer_index) begin
                  slot_prefix[i] = '0;
                  slot_len[i] = '0;
                  slot_peer[i] = '0;
                  slot_used[i] = 1'b0;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic queue_cmd(input cmd_type c, input addr_type a, input len_type l,
                            input peer_type p);
      route_req_type r;
      r.command = c;
      r.ip_addr = a;
      r.prefix_len = l;
      r.peer_index = p;
      cmd_backlog.push_back(r);
      if (c == CMD_INSERT) begin
         recent_prefixes.push_back(r);
         if (recent_prefixes.size() > RECENT_DEPTH) void'(recent_prefixes.pop_front());
      end
   endtask

   // Mostly a small set of peers so that removes hit many slots at once.
   function automatic peer_type pick_peer();
      if ($urandom_range(0, 9) == 0) return peer_type'($urandom_range(0, 255));
      return peer_type'($urandom_range(0, 7));
   endfunction

   function automatic len_type pick_len();
      if ($urandom_range(0, 9) == 0) return len_type'($urandom_range(33, 63));
      return len_type'($urandom_range(0, 32));
   endfunction

   // An address inside a prefix inserted lately, or now and then any address.
   function automatic addr_type pick_dest();
      route_req_type base;
      addr_type      mask;
      if (recent_prefixes.size() == 0 || $urandom_range(0, 3) == 0) return $urandom;
      base = recent_prefixes[$urandom_range(0, recent_prefixes.size() - 1)];
      mask = prefix_mask(clamp_len(base.prefix_len));
      return (base.ip_addr & mask) | ($urandom & ~mask);
   endfunction

   function automatic int idle_odds();
      return (req_beats >= QUIET_FROM && req_beats < QUIET_TO) ? 0 : 34;
   endfunction

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Request monitor: every accepted beat updates the predicted table.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_prefix[i] = '0;
            slot_len[i] = '0;
            slot_peer[i] = '0;
            slot_used[i] = 1'b0;
         end
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            awaited_rsp.push_back(table_apply({req_if.command, req_if.ip_addr,
                                               req_if.prefix_len, req_if.peer_index}));
            req_beats <= req_beats + 1;
         end
      end
   end

   // Response monitor: compares each beat with the oldest prediction.
   always @(posedge clock) begin : rsp_monitor
      route_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_rsp.size() == 0) begin
            report_mismatch($sformatf("response beat with none expected (status %0d peer %0d)",
                                      rsp_if.status, rsp_if.found_peer));
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_if.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_if.status,
                                         want.status));
            if (rsp_if.found_peer !== want.found_peer)
               report_mismatch($sformatf("found_peer %0d, expected %0d", rsp_if.found_peer,
                                         want.found_peer));
         end
      end
   end

   // One long receiver hold-off, so the block holds its response and stalls the sender.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && req_beats == HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Request driver: offers the next pending beat once the current one is taken.
   always @(negedge clock) begin : req_driver
      route_req_type nxt;
      if (!reset && (!req_if.valid || req_taken)) begin
         if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= idle_odds()) begin
            nxt = cmd_backlog.pop_front();
            req_if.valid <= 1'b1;
            req_if.command <= nxt.command;
            req_if.ip_addr <= nxt.ip_addr;
            req_if.prefix_len <= nxt.prefix_len;
            req_if.peer_index <= nxt.peer_index;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response ready with random stalls and the hold-off.
   always @(negedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_odds());
   end

   initial begin
      wait (cycle_count == LIMIT_CYCLES);
      $display("[prefix_table_longest_match] ERROR");
      $finish;
   end

   initial begin : stimulus
      int            kind;
      int            burst;
      route_req_type base;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.command = CMD_INSERT;
      req_if.ip_addr = '0;
      req_if.prefix_len = '0;
      req_if.peer_index = '0;
      rsp_if.ready = 1'b0;

      // Directed part: nested prefixes, default route, saturated lengths, update,
      // removes of present and absent peers, the unused command and field extremes.
      queue_cmd(CMD_LOOKUP, 32'h0A01_0203, 6'd0, 8'd0);
      queue_cmd(CMD_INSERT, 32'h0A37_4D4D, 6'd8, 8'd2);
      queue_cmd(CMD_INSERT, 32'h0A01_FFFF, 6'd16, 8'd3);
      queue_cmd(CMD_INSERT, 32'h0A01_0203, 6'd32, 8'd4);
      queue_cmd(CMD_LOOKUP, 32'h0A01_0203, 6'd0, 8'd0);
      queue_cmd(CMD_LOOKUP, 32'h0A01_0909, 6'd0, 8'd0);
      queue_cmd(CMD_LOOKUP, 32'h0AC8_0000, 6'd0, 8'd0);
      queue_cmd(CMD_LOOKUP, 32'h0B00_0000, 6'd0, 8'd0);
      queue_cmd(CMD_INSERT, 32'h1234_5678, 6'd0, 8'd1);
      queue_cmd(CMD_LOOKUP, 32'h0B00_0000, 6'd0, 8'd0);
      queue_cmd(CMD_INSERT, 32'hC0A8_0101, 6'd63, 8'd5);
      queue_cmd(CMD_LOOKUP, 32'hC0A8_0101, 6'd0, 8'd0);
      queue_cmd(CMD_INSERT, FULL_MASK, 6'd33, 8'd255);
      queue_cmd(CMD_LOOKUP, FULL_MASK, 6'd63, 8'd255);
      queue_cmd(CMD_INSERT, 32'h0A00_0000, 6'd8, 8'd6);
      queue_cmd(CMD_LOOKUP, 32'h0A7F_0000, 6'd0, 8'd0);
      queue_cmd(CMD_REMOVE, 32'h0, 6'd0, 8'd1);
      queue_cmd(CMD_LOOKUP, 32'h0B00_0000, 6'd0, 8'd0);
      queue_cmd(CMD_REMOVE, FULL_MASK, 6'd63, 8'd77);
      queue_cmd(CMD_UNUSED, FULL_MASK, 6'd63, 8'd255);
      queue_cmd(CMD_INSERT, 32'h0, 6'd32, 8'd0);
      queue_cmd(CMD_LOOKUP, 32'h0, 6'd0, 8'd0);
      queue_cmd(CMD_REMOVE, 32'h0, 6'd0, 8'd255);
      queue_cmd(CMD_LOOKUP, FULL_MASK, 6'd0, 8'd0);
      queue_cmd(CMD_LOOKUP, 32'h0A01_0203, 6'd0, 8'd0);

      // Random part in bursts: fill runs that reach a full table, lookup runs
      // aimed at stored prefixes, peer removes and unconstrained noise.
      while (cmd_backlog.size() < RANDOM_ITEMS + 25) begin
         kind = $urandom_range(0, 9);
         if (kind <= 2) begin
            burst = $urandom_range(8, 40);
            repeat (burst) begin
               if (recent_prefixes.size() != 0 && $urandom_range(0, 5) == 0) begin
                  base = recent_prefixes[$urandom_range(0, recent_prefixes.size() - 1)];
                  queue_cmd(CMD_INSERT, base.ip_addr, base.prefix_len, pick_peer());
               end else begin
                  queue_cmd(CMD_INSERT, $urandom, pick_len(), pick_peer());
               end
               if ($urandom_range(0, 3) == 0)
                  queue_cmd(CMD_LOOKUP, pick_dest(), pick_len(), pick_peer());
            end
         end else if (kind <= 5) begin
            burst = $urandom_range(5, 20);
            repeat (burst) queue_cmd(CMD_LOOKUP, pick_dest(), pick_len(), pick_peer());
         end else if (kind <= 7) begin
            burst = $urandom_range(1, 4);
            repeat (burst) begin
               queue_cmd(CMD_REMOVE, $urandom, pick_len(), pick_peer());
               queue_cmd(CMD_LOOKUP, pick_dest(), pick_len(), pick_peer());
            end
         end else begin
            burst = $urandom_range(1, 6);
            repeat (burst)
               queue_cmd(cmd_type'($urandom_range(0, 3)), $urandom,
                         len_type'($urandom_range(0, 63)), peer_type'($urandom_range(0, 255)));
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Wait for every beat to be sent and answered, then let the block settle.
      while (cmd_backlog.size() != 0 || req_if.valid || awaited_rsp.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("[prefix_table_longest_match] OK");
      end else begin
         $display("[prefix_table_longest_match] ERROR");
      end
      $finish;
   end

endmodule
